[rtl/rdf_pkg.sv]
`default_nettype none
// ============================================================================
// rdf_pkg - shared types and constants of the raster fill engine
// Frame store geometry, field widths, command codes and the control/status
// bundles passed between the controller and the datapath.
// ============================================================================
package rdf_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CH_W      = 8;
    localparam int PIX_W     = 4 * CH_W;
    localparam int POS_W     = 12;
    localparam int DIM_W     = 8;
    localparam int FULL_W    = 2 * DIM_W;
    localparam int COORD_W   = 14;
    localparam int DY_W      = 10;
    localparam int HALF_W    = 9;
    localparam int SPAN_W    = HALF_W + 1;
    localparam int SQ_W      = 2 * DY_W;
    localparam int PROD_W    = 2 * CH_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] CANVAS_RESET = DIM_W'(128);

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ACT_RECT = 2'd0,
        ACT_DISC = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef struct packed {
        logic premul;
        logic pack;
        logic rect_load;
        logic disc_row;
        logic disc_test;
        logic span_load;
        logic bounds;
        logic base;
        logic run;
        logic disc_next;
        logic read_addr;
        logic out_load;
        logic clear_step;
    } dp_cmd_t;

    typedef struct packed {
        action_t act;
        logic    disc_more;
        logic    disc_pass;
        logic    rect_empty;
        logic    run_last;
        logic    clear_last;
        logic    out_free;
    } dp_stat_t;

    // p / 255 for p up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = (PROD_W+1)'(p) + (PROD_W+1)'(p >> CH_W) + (PROD_W+1)'(1);
        return t[PROD_W-1:CH_W];
    endfunction

endpackage
`default_nettype wire

[rtl/rdf_cmd_if.sv]
`default_nettype none
// ============================================================================
// rdf_cmd_if - command channel
// One drawing or read request per handshake.
// ============================================================================
interface rdf_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic signed [rdf_pkg::POS_W-1:0]    x_pos;
    logic signed [rdf_pkg::POS_W-1:0]    y_pos;
    logic [rdf_pkg::DIM_W-1:0]           rect_width;
    logic [rdf_pkg::DIM_W-1:0]           rect_height;
    logic [rdf_pkg::DIM_W-1:0]           radius;
    logic [rdf_pkg::CH_W-1:0]            red;
    logic [rdf_pkg::CH_W-1:0]            green;
    logic [rdf_pkg::CH_W-1:0]            blue;
    logic [rdf_pkg::CH_W-1:0]            alpha;

    modport source (
        output valid, action, x_pos, y_pos, rect_width, rect_height, radius,
               red, green, blue, alpha,
        input  ready
    );
    modport sink (
        input  valid, action, x_pos, y_pos, rect_width, rect_height, radius,
               red, green, blue, alpha,
        output ready
    );
endinterface
`default_nettype wire

[rtl/rdf_pix_if.sv]
`default_nettype none
// ============================================================================
// rdf_pix_if - pixel result channel
// One stored pixel per handshake, returned for a read request.
// ============================================================================
interface rdf_pix_if;
    logic                         valid;
    logic                         ready;
    logic [rdf_pkg::CH_W-1:0]     pixel_red;
    logic [rdf_pkg::CH_W-1:0]     pixel_green;
    logic [rdf_pkg::CH_W-1:0]     pixel_blue;
    logic [rdf_pkg::CH_W-1:0]     pixel_alpha;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
        output ready
    );
endinterface
`default_nettype wire

[rtl/rect_and_disc_raster_fill.sv]
`default_nettype none
// ============================================================================
// rect_and_disc_raster_fill - rectangle and disc fill engine, top level
// Premultiplied RGBA rectangle and disc fills over a cleared frame store,
// with single-pixel read-back.
// ============================================================================
//
// channel   dir   handshake          payload
// cmd       in    valid / ready      action, x_pos, y_pos, rect_width,
//                                    rect_height, radius, red, green, blue, alpha
// pix       out   valid / ready      pixel_red, pixel_green, pixel_blue, pixel_alpha
// cfg       in    cfg_write_en       cfg_index, cfg_data
//
// One request at a time. Fill: premultiply, pack, clip and row-base steps, then a
// store write per clipped pixel. Disc: premultiply and pack, then per row the span
// search, clip, row base and a write per clipped pixel over 2*radius rows, and a
// closing check; the span search steps once a cycle. Read: address, store read
// and result register; a held result stalls a further read only. After reset the
// store is swept to zero, one word a cycle, all 16384 words with ready low.
//
module rect_and_disc_raster_fill (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    rdf_cmd_if.sink                                 cmd,
    rdf_pix_if.source                               pix,
    input  wire logic                               cfg_write_en,
    input  wire logic [rdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rdf_pkg::DIM_W-1:0]          cfg_data
);

    rdf_pkg::dp_cmd_t   ctl;
    rdf_pkg::dp_stat_t  stat;
    logic               in_ready;
    logic               in_accept;

    assign cmd.ready = in_ready;
    assign in_accept = cmd.valid && in_ready;

    rdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    rdf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .action       (cmd.action),
        .x_pos        (cmd.x_pos),
        .y_pos        (cmd.y_pos),
        .rect_width   (cmd.rect_width),
        .rect_height  (cmd.rect_height),
        .radius       (cmd.radius),
        .red          (cmd.red),
        .green        (cmd.green),
        .blue         (cmd.blue),
        .alpha        (cmd.alpha),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .stat         (stat),
        .pix_valid    (pix.valid),
        .pix_ready    (pix.ready),
        .pixel_red    (pix.pixel_red),
        .pixel_green  (pix.pixel_green),
        .pixel_blue   (pix.pixel_blue),
        .pixel_alpha  (pix.pixel_alpha)
    );

endmodule
`default_nettype wire

[rtl/rdf_store.sv]
`default_nettype none
// ============================================================================
// rdf_store - frame store
// Single write port, single registered read port, RGBA words.
// ============================================================================
module rdf_store (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [rdf_pkg::ADDR_W-1:0]    waddr,
    input  wire logic [rdf_pkg::PIX_W-1:0]     wdata,
    input  wire logic [rdf_pkg::ADDR_W-1:0]    raddr,
    output      logic [rdf_pkg::PIX_W-1:0]     rdata
);

    logic [rdf_pkg::PIX_W-1:0] mem [rdf_pkg::STORE_DEPTH];
    logic [rdf_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/rdf_ctrl.sv]
`default_nettype none
// ============================================================================
// rdf_ctrl - sequencer
// Clear pass, request intake, colour setup, disc row loop, span/rectangle
// walk and read-back, issuing one command word per state.
// ============================================================================
module rdf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire rdf_pkg::dp_stat_t  stat,
    output      rdf_pkg::dp_cmd_t   ctl
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREMUL,
        S_PACK,
        S_DISC_ROW,
        S_DISC_TEST,
        S_SPAN,
        S_BOUNDS,
        S_BASE,
        S_RUN,
        S_DISC_NEXT,
        S_READ_ADDR,
        S_READ_MEM,
        S_READ_OUT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    state_t             after_rect;
    rdf_pkg::dp_cmd_t   ctl_reg;
    logic               ready_reg;

    function automatic rdf_pkg::dp_cmd_t cmd_of(input state_t s);
        rdf_pkg::dp_cmd_t c;
        c = '0;
        case (s)
            S_CLEAR:     c.clear_step = 1'b1;
            S_PREMUL:    c.premul     = 1'b1;
            S_PACK:
            begin
                c.pack      = 1'b1;
                c.rect_load = 1'b1;
            end
            S_DISC_ROW:  c.disc_row   = 1'b1;
            S_DISC_TEST: c.disc_test  = 1'b1;
            S_SPAN:      c.span_load  = 1'b1;
            S_BOUNDS:    c.bounds     = 1'b1;
            S_BASE:      c.base       = 1'b1;
            S_RUN:       c.run        = 1'b1;
            S_DISC_NEXT: c.disc_next  = 1'b1;
            S_READ_ADDR: c.read_addr  = 1'b1;
            S_READ_OUT:  c.out_load   = 1'b1;
            default:     c = '0;
        endcase
        return c;
    endfunction

    assign after_rect = (stat.act == rdf_pkg::ACT_DISC) ? S_DISC_NEXT : S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    state_next = S_PREMUL;
                end
            end
            S_PREMUL:    state_next = S_PACK;
            S_PACK:
            begin
                case (stat.act)
                    rdf_pkg::ACT_RECT: state_next = S_BOUNDS;
                    rdf_pkg::ACT_DISC: state_next = S_DISC_ROW;
                    rdf_pkg::ACT_READ: state_next = S_READ_ADDR;
                    default:           state_next = S_IDLE;
                endcase
            end
            S_DISC_ROW:  state_next = stat.disc_more ? S_DISC_TEST : S_IDLE;
            S_DISC_TEST:
            begin
                if (!stat.disc_pass)
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:      state_next = S_BOUNDS;
            S_BOUNDS:    state_next = S_BASE;
            S_BASE:      state_next = stat.rect_empty ? after_rect : S_RUN;
            S_RUN:
            begin
                if (stat.run_last)
                begin
                    state_next = after_rect;
                end
            end
            S_DISC_NEXT: state_next = S_DISC_ROW;
            S_READ_ADDR: state_next = S_READ_MEM;
            S_READ_MEM:  state_next = S_READ_OUT;
            S_READ_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ctl_reg   <= cmd_of(S_CLEAR);
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctl_reg   <= cmd_of(state_next);
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign ctl      = ctl_reg;
    assign in_ready = ready_reg;

endmodule
`default_nettype wire

[rtl/rdf_dp.sv]
`default_nettype none
// ============================================================================
// rdf_dp - raster datapath
// Request latch, premultiply, disc span search, clipping, pixel walk,
// read-back, canvas registers, clear counter and result register.
// ============================================================================
module rdf_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_accept,
    input  wire logic [1:0]                        action,
    input  wire logic signed [rdf_pkg::POS_W-1:0]  x_pos,
    input  wire logic signed [rdf_pkg::POS_W-1:0]  y_pos,
    input  wire logic [rdf_pkg::DIM_W-1:0]         rect_width,
    input  wire logic [rdf_pkg::DIM_W-1:0]         rect_height,
    input  wire logic [rdf_pkg::DIM_W-1:0]         radius,
    input  wire logic [rdf_pkg::CH_W-1:0]          red,
    input  wire logic [rdf_pkg::CH_W-1:0]          green,
    input  wire logic [rdf_pkg::CH_W-1:0]          blue,
    input  wire logic [rdf_pkg::CH_W-1:0]          alpha,
    input  wire logic                              cfg_write_en,
    input  wire logic [rdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rdf_pkg::DIM_W-1:0]         cfg_data,
    input  wire rdf_pkg::dp_cmd_t                  ctl,
    output      rdf_pkg::dp_stat_t                 stat,
    output      logic                              pix_valid,
    input  wire logic                              pix_ready,
    output      logic [rdf_pkg::CH_W-1:0]          pixel_red,
    output      logic [rdf_pkg::CH_W-1:0]          pixel_green,
    output      logic [rdf_pkg::CH_W-1:0]          pixel_blue,
    output      logic [rdf_pkg::CH_W-1:0]          pixel_alpha
);

    localparam int CH_W    = rdf_pkg::CH_W;
    localparam int POS_W   = rdf_pkg::POS_W;
    localparam int DIM_W   = rdf_pkg::DIM_W;
    localparam int FULL_W  = rdf_pkg::FULL_W;
    localparam int COORD_W = rdf_pkg::COORD_W;
    localparam int DY_W    = rdf_pkg::DY_W;
    localparam int HALF_W  = rdf_pkg::HALF_W;
    localparam int SPAN_W  = rdf_pkg::SPAN_W;
    localparam int SQ_W    = rdf_pkg::SQ_W;
    localparam int PROD_W  = rdf_pkg::PROD_W;
    localparam int ADDR_W  = rdf_pkg::ADDR_W;
    localparam int PIX_W   = rdf_pkg::PIX_W;
    localparam int CLIP_W  = COORD_W + 1;
    localparam int SUM_W   = SQ_W + 1;

    // request latch
    rdf_pkg::action_t            act_reg;
    logic signed [POS_W-1:0]     x_reg;
    logic signed [POS_W-1:0]     y_reg;
    logic [DIM_W-1:0]            fw_reg;
    logic [DIM_W-1:0]            fh_reg;
    logic [DIM_W-1:0]            rad_reg;
    logic [CH_W-1:0]             red_reg;
    logic [CH_W-1:0]             green_reg;
    logic [CH_W-1:0]             blue_reg;
    logic [CH_W-1:0]             alpha_reg;

    // colour and disc setup
    logic [PROD_W-1:0]           prod_r_reg;
    logic [PROD_W-1:0]           prod_g_reg;
    logic [PROD_W-1:0]           prod_b_reg;
    logic [PROD_W-1:0]           rad_sq_reg;
    logic [PIX_W-1:0]            word_reg;
    logic [SQ_W-1:0]             limit_reg;
    logic signed [DY_W-1:0]      dy_reg;
    logic [SQ_W-1:0]             yt2_reg;
    logic [HALF_W-1:0]           half_reg;
    logic [SQ_W-1:0]             odd_sq_reg;

    // rectangle walk
    logic signed [COORD_W-1:0]   rx_reg;
    logic signed [COORD_W-1:0]   ry_reg;
    logic [SPAN_W-1:0]           rw_reg;
    logic [DIM_W-1:0]            rh_reg;
    logic [DIM_W-1:0]            x0_reg;
    logic [DIM_W-1:0]            x1_reg;
    logic [DIM_W-1:0]            y0_reg;
    logic [DIM_W-1:0]            y1_reg;
    logic                        empty_reg;
    logic [DIM_W-1:0]            xx_reg;
    logic [DIM_W-1:0]            yy_reg;
    logic [FULL_W-1:0]           row_base_reg;

    // read-back and control
    logic [ADDR_W-1:0]           raddr_reg;
    logic                        read_ok_reg;
    logic [DIM_W-1:0]            canvas_w_reg;
    logic [DIM_W-1:0]            canvas_h_reg;
    logic [ADDR_W-1:0]           clear_cnt_reg;
    logic                        out_valid_reg;
    logic [PIX_W-1:0]            out_word_reg;

    logic [DIM_W-1:0]            eff_w;
    logic [DIM_W-1:0]            eff_h;
    logic signed [DY_W-1:0]      yt;
    logic signed [SQ_W-1:0]      yt_sq;
    logic                        pass;
    logic signed [CLIP_W-1:0]    x0s;
    logic signed [CLIP_W-1:0]    x1s;
    logic signed [CLIP_W-1:0]    xe;
    logic signed [CLIP_W-1:0]    y0s;
    logic signed [CLIP_W-1:0]    y1s;
    logic signed [CLIP_W-1:0]    ye;
    logic signed [CLIP_W-1:0]    ws;
    logic signed [CLIP_W-1:0]    hs;
    logic [DIM_W:0]              xx_inc;
    logic [DIM_W:0]              yy_inc;
    logic                        row_end;
    logic [FULL_W-1:0]           addr_full;
    logic                        addr_ok;
    logic signed [POS_W:0]       xs;
    logic signed [POS_W:0]       ys;
    logic signed [POS_W:0]       wr;
    logic signed [POS_W:0]       hr;
    logic                        in_canvas;
    logic [FULL_W-1:0]           raddr_full;
    logic                        out_free;
    logic                        store_we;
    logic [ADDR_W-1:0]           store_waddr;
    logic [PIX_W-1:0]            store_wdata;
    logic [PIX_W-1:0]            store_rdata;

    assign eff_w = (32'(canvas_w_reg) > rdf_pkg::MAX_WIDTH)
                 ? DIM_W'(rdf_pkg::MAX_WIDTH) : canvas_w_reg;
    assign eff_h = (32'(canvas_h_reg) > rdf_pkg::MAX_HEIGHT)
                 ? DIM_W'(rdf_pkg::MAX_HEIGHT) : canvas_h_reg;

    // disc row test: (2*half+1)^2 + (2*dy+1)^2 <= 4*radius^2
    assign yt    = $signed({dy_reg[DY_W-2:0], 1'b1});
    assign yt_sq = yt * yt;
    assign pass  = (SUM_W'(odd_sq_reg) + SUM_W'(yt2_reg)) <= SUM_W'(limit_reg);

    // clipping
    assign ws  = $signed(CLIP_W'(eff_w));
    assign hs  = $signed(CLIP_W'(eff_h));
    assign xe  = CLIP_W'(rx_reg) + $signed(CLIP_W'(rw_reg));
    assign ye  = CLIP_W'(ry_reg) + $signed(CLIP_W'(rh_reg));
    assign x0s = (rx_reg < 0) ? '0 : CLIP_W'(rx_reg);
    assign y0s = (ry_reg < 0) ? '0 : CLIP_W'(ry_reg);
    assign x1s = (xe < ws) ? xe : ws;
    assign y1s = (ye < hs) ? ye : hs;

    // pixel walk
    assign xx_inc    = (DIM_W+1)'(xx_reg) + (DIM_W+1)'(1);
    assign yy_inc    = (DIM_W+1)'(yy_reg) + (DIM_W+1)'(1);
    assign row_end   = (xx_inc == (DIM_W+1)'(x1_reg));
    assign addr_full = row_base_reg + FULL_W'(xx_reg);
    assign addr_ok   = 32'(addr_full) < rdf_pkg::STORE_DEPTH;

    // read-back
    assign xs     = x_reg;
    assign ys     = y_reg;
    assign wr     = $signed((POS_W+1)'(eff_w));
    assign hr     = $signed((POS_W+1)'(eff_h));
    assign in_canvas = (xs >= 0) && (xs < wr) && (ys >= 0) && (ys < hr);
    assign raddr_full = FULL_W'(y_reg[DIM_W-1:0]) * FULL_W'(eff_w)
                      + FULL_W'(x_reg[DIM_W-1:0]);

    assign out_free = !out_valid_reg || pix_ready;

    assign store_we    = ctl.clear_step || (ctl.run && addr_ok);
    assign store_waddr = ctl.clear_step ? clear_cnt_reg : addr_full[ADDR_W-1:0];
    assign store_wdata = ctl.clear_step ? '0 : word_reg;

    rdf_store u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (raddr_reg),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg  <= rdf_pkg::CANVAS_RESET;
            canvas_h_reg  <= rdf_pkg::CANVAS_RESET;
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    rdf_pkg::REG_CANVAS_WIDTH:  canvas_w_reg <= cfg_data;
                    rdf_pkg::REG_CANVAS_HEIGHT: canvas_h_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctl.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + ADDR_W'(1);
            end
            if (ctl.out_load && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg   <= rdf_pkg::action_t'(action);
            x_reg     <= x_pos;
            y_reg     <= y_pos;
            fw_reg    <= rect_width;
            fh_reg    <= rect_height;
            rad_reg   <= radius;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
        end
        if (ctl.premul)
        begin
            prod_r_reg <= PROD_W'(red_reg) * PROD_W'(alpha_reg);
            prod_g_reg <= PROD_W'(green_reg) * PROD_W'(alpha_reg);
            prod_b_reg <= PROD_W'(blue_reg) * PROD_W'(alpha_reg);
            rad_sq_reg <= PROD_W'(rad_reg) * PROD_W'(rad_reg);
            dy_reg     <= -$signed(DY_W'(rad_reg));
        end
        if (ctl.pack)
        begin
            word_reg  <= {alpha_reg, rdf_pkg::div255(prod_b_reg),
                          rdf_pkg::div255(prod_g_reg), rdf_pkg::div255(prod_r_reg)};
            limit_reg <= SQ_W'({rad_sq_reg, 2'b00});
        end
        if (ctl.rect_load)
        begin
            rx_reg <= COORD_W'(x_reg);
            ry_reg <= COORD_W'(y_reg);
            rw_reg <= SPAN_W'(fw_reg);
            rh_reg <= fh_reg;
        end
        if (ctl.disc_row)
        begin
            yt2_reg    <= $unsigned(yt_sq);
            half_reg   <= '0;
            odd_sq_reg <= SQ_W'(1);
        end
        if (ctl.disc_test && pass)
        begin
            half_reg   <= half_reg + HALF_W'(1);
            // (2h+3)^2 - (2h+1)^2 = 8h + 8
            odd_sq_reg <= odd_sq_reg + SQ_W'({half_reg, 3'b000}) + SQ_W'(8);
        end
        if (ctl.span_load)
        begin
            rx_reg <= COORD_W'(x_reg) - $signed(COORD_W'(half_reg));
            ry_reg <= COORD_W'(y_reg) + COORD_W'(dy_reg);
            rw_reg <= {half_reg, 1'b0};
            rh_reg <= DIM_W'(1);
        end
        if (ctl.bounds)
        begin
            x0_reg    <= x0s[DIM_W-1:0];
            x1_reg    <= x1s[DIM_W-1:0];
            y0_reg    <= y0s[DIM_W-1:0];
            y1_reg    <= y1s[DIM_W-1:0];
            empty_reg <= (x0s >= x1s) || (y0s >= y1s);
        end
        if (ctl.base)
        begin
            row_base_reg <= FULL_W'(y0_reg) * FULL_W'(eff_w);
            xx_reg       <= x0_reg;
            yy_reg       <= y0_reg;
        end
        if (ctl.run)
        begin
            if (row_end)
            begin
                xx_reg       <= x0_reg;
                yy_reg       <= yy_inc[DIM_W-1:0];
                row_base_reg <= row_base_reg + FULL_W'(eff_w);
            end
            else
            begin
                xx_reg <= xx_inc[DIM_W-1:0];
            end
        end
        if (ctl.disc_next)
        begin
            dy_reg <= dy_reg + $signed(DY_W'(1));
        end
        if (ctl.read_addr)
        begin
            raddr_reg   <= raddr_full[ADDR_W-1:0];
            read_ok_reg <= in_canvas && (32'(raddr_full) < rdf_pkg::STORE_DEPTH);
        end
        if (ctl.out_load && out_free)
        begin
            out_word_reg <= read_ok_reg ? store_rdata : '0;
        end
    end

    assign stat.act        = act_reg;
    assign stat.disc_more  = dy_reg < $signed(DY_W'(rad_reg));
    assign stat.disc_pass  = pass;
    assign stat.rect_empty = empty_reg;
    assign stat.run_last   = row_end && (yy_inc == (DIM_W+1)'(y1_reg));
    assign stat.clear_last = (clear_cnt_reg == ADDR_W'(rdf_pkg::STORE_DEPTH - 1));
    assign stat.out_free   = out_free;

    assign pix_valid   = out_valid_reg;
    assign pixel_red   = out_word_reg[CH_W-1:0];
    assign pixel_green = out_word_reg[2*CH_W-1:CH_W];
    assign pixel_blue  = out_word_reg[3*CH_W-1:2*CH_W];
    assign pixel_alpha = out_word_reg[4*CH_W-1:3*CH_W];

endmodule
`default_nettype wire

[rtl/rdf_checker.sv]
`default_nettype none
// ============================================================================
// rdf_checker - port-level checks
// Reset sweep, one request in flight, and result timing and hold as seen at the
// ports of the fill engine.
// ============================================================================
module rdf_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rdf_cmd_if.sink     cmd,
    rdf_pix_if.source   pix
);

    // store sweep runs straight after reset
    a_sweep_after_reset: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !cmd.ready
    ) else $error("request taken during the reset sweep");

    a_one_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready
    ) else $error("second request taken back to back");

    a_result_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(pix.valid) |-> $past(!cmd.ready)
    ) else $error("result raised while engine was idle");

    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        pix.valid && !pix.ready |=> pix.valid && $stable(pix.pixel_red)
            && $stable(pix.pixel_green) && $stable(pix.pixel_blue)
            && $stable(pix.pixel_alpha)
    ) else $error("stalled result changed");

endmodule

bind rect_and_disc_raster_fill rdf_checker u_rdf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .pix   (pix)
);
`default_nettype wire

[tb/rect_and_disc_raster_fill_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// rect_and_disc_raster_fill_tb - self-checking bench for the raster fill engine
// Drives rectangle, disc and read requests through the command channel and
// keeps a shadow frame store of its own, updated as each request is taken.
// Every read result is compared field by field with the shadow pixel.
// The bench covers canvas register settings, bursty requests with random
// gaps, result stalls and a long hold-off that backs the engine up.
// ============================================================================
module rect_and_disc_raster_fill_tb;
    import rdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int RANDOM_PER_PHASE = 170;

    typedef struct {
        action_t                 act;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [DIM_W-1:0]        rect_width;
        logic [DIM_W-1:0]        rect_height;
        logic [DIM_W-1:0]        radius;
        logic [CH_W-1:0]         red;
        logic [CH_W-1:0]         green;
        logic [CH_W-1:0]         blue;
        logic [CH_W-1:0]         alpha;
    } draw_request_t;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba_t;

    typedef enum {TAKE_ALL, TAKE_HALF, TAKE_QUARTER, TAKE_PERIODIC} stall_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    rdf_cmd_if cmd_bus ();
    rdf_pix_if pix_bus ();

    rect_and_disc_raster_fill DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_bus),
        .pix          (pix_bus),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rgba_t shadow_store [0:STORE_DEPTH-1];
    int    canvas_cols;
    int    canvas_rows;
    rgba_t pending_pixels [$];
    int    mismatch_count;
    int    burst_left;
    int    result_hold_cycles;
    int    quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow frame store
    // ------------------------------------------------------------------------
    function automatic int active_cols();
        return (canvas_cols > MAX_WIDTH) ? MAX_WIDTH : canvas_cols;
    endfunction

    function automatic int active_rows();
        return (canvas_rows > MAX_HEIGHT) ? MAX_HEIGHT : canvas_rows;
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_store[i])
            shadow_store[i] = '0;
        canvas_cols = 128;
        canvas_rows = 128;
    endfunction

    function automatic rgba_t premultiplied(draw_request_t q);
        rgba_t c;
        int    a;
        a = q.alpha;
        c.red   = CH_W'(int'(q.red) * a / 255);
        c.green = CH_W'(int'(q.green) * a / 255);
        c.blue  = CH_W'(int'(q.blue) * a / 255);
        c.alpha = q.alpha;
        return c;
    endfunction

    function automatic void paint_box(int x, int y, int fw, int fh, rgba_t colour);
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int addr;
        w  = active_cols();
        h  = active_rows();
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = (x + fw < w) ? x + fw : w;
        y1 = (y + fh < h) ? y + fh : h;
        for (int yy = y0; yy < y1; yy++)
            for (int xx = x0; xx < x1; xx++)
            begin
                addr = yy * w + xx;
                if (addr < STORE_DEPTH)
                    shadow_store[addr] = colour;
            end
    endfunction

    function automatic void paint_disc(int x, int y, int rad, rgba_t colour);
        int lim;
        int yt;
        int half;
        lim = 4 * rad * rad;
        for (int dy = -rad; dy < rad; dy++)
        begin
            yt   = 2 * dy + 1;
            half = 0;
            while ((2 * half + 1) * (2 * half + 1) + yt * yt <= lim)
                half++;
            paint_box(x - half, y + dy, 2 * half, 1, colour);
        end
    endfunction

    function automatic void track_request(draw_request_t q);
        int    x;
        int    y;
        rgba_t pix;
        x = q.x_pos;
        y = q.y_pos;
        case (q.act)
            ACT_RECT: paint_box(x, y, q.rect_width, q.rect_height, premultiplied(q));
            ACT_DISC: paint_disc(x, y, q.radius, premultiplied(q));
            ACT_READ:
            begin
                pix = '0;
                if (x >= 0 && x < active_cols() && y >= 0 && y < active_rows()
                    && y * active_cols() + x < STORE_DEPTH)
                    pix = shadow_store[y * active_cols() + x];
                pending_pixels.push_back(pix);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------------
    function automatic draw_request_t make_request(action_t act, int x, int y,
                                                   int fw, int fh, int rad,
                                                   int r, int g, int b, int a);
        draw_request_t q;
        q.act         = act;
        q.x_pos       = POS_W'(x);
        q.y_pos       = POS_W'(y);
        q.rect_width  = DIM_W'(fw);
        q.rect_height = DIM_W'(fh);
        q.radius      = DIM_W'(rad);
        q.red         = CH_W'(r);
        q.green       = CH_W'(g);
        q.blue        = CH_W'(b);
        q.alpha       = CH_W'(a);
        return q;
    endfunction

    function automatic draw_request_t random_request();
        draw_request_t q;
        int            pick;
        int            cols;
        int            rows;
        cols = active_cols();
        rows = active_rows();
        pick = $urandom_range(0, 99);
        q.act = (pick < 35) ? ACT_RECT : (pick < 55) ? ACT_DISC :
                (pick < 95) ? ACT_READ : ACT_NONE;
        q.red   = CH_W'($urandom);
        q.green = CH_W'($urandom);
        q.blue  = CH_W'($urandom);
        q.alpha = CH_W'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: anywhere in the coordinate range, any rectangle size, radius up to 31
            q.x_pos       = POS_W'($urandom);
            q.y_pos       = POS_W'($urandom);
            q.rect_width  = DIM_W'($urandom);
            q.rect_height = DIM_W'($urandom);
            q.radius      = DIM_W'($urandom_range(0, 31));
        end
        else
        begin
            q.x_pos = POS_W'(int'($urandom_range(0, cols + 15)) - 8);
            q.y_pos = POS_W'(int'($urandom_range(0, rows + 15)) - 8);
            if ($urandom_range(0, 19) == 0)
            begin
                q.rect_width  = DIM_W'($urandom);
                q.rect_height = DIM_W'($urandom_range(0, 40));
            end
            else
            begin
                q.rect_width  = DIM_W'($urandom_range(0, 20));
                q.rect_height = DIM_W'($urandom_range(0, 20));
            end
            q.radius = ($urandom_range(0, 29) == 0) ? DIM_W'($urandom_range(13, 40))
                                                     : DIM_W'($urandom_range(0, 12));
            if (q.act == ACT_READ && cols > 0 && rows > 0 && $urandom_range(0, 9) != 0)
            begin
                q.x_pos = POS_W'($urandom_range(0, cols - 1));
                q.y_pos = POS_W'($urandom_range(0, rows - 1));
            end
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Request channel and configuration port
    // ------------------------------------------------------------------------
    task automatic send_request(input draw_request_t q);
        cmd_bus.valid       <= 1'b1;
        cmd_bus.action      <= q.act;
        cmd_bus.x_pos       <= q.x_pos;
        cmd_bus.y_pos       <= q.y_pos;
        cmd_bus.rect_width  <= q.rect_width;
        cmd_bus.rect_height <= q.rect_height;
        cmd_bus.radius      <= q.radius;
        cmd_bus.red         <= q.red;
        cmd_bus.green       <= q.green;
        cmd_bus.blue        <= q.blue;
        cmd_bus.alpha       <= q.alpha;
        do
            @(posedge clk);
        while (!(cmd_bus.valid && cmd_bus.ready));
        track_request(q);
        burst_left--;
        if (burst_left <= 0)
        begin
            cmd_bus.valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(8, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
    endtask

    task automatic idle_sender();
        if (cmd_bus.valid)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // a read queues behind any fill still running, so its result marks idle
    task automatic settle_block();
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        idle_sender();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_CANVAS_WIDTH)
            canvas_cols = value;
        else if (idx == REG_CANVAS_HEIGHT)
            canvas_rows = value;
        @(posedge clk);
    endtask

    task automatic resize_canvas(input int cols, input int rows);
        settle_block();
        set_register(REG_CANVAS_WIDTH, DIM_W'(cols));
        set_register(REG_CANVAS_HEIGHT, DIM_W'(rows));
    endtask

    // ------------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------------
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        pix_bus.ready <= 1'b0;
        mode      = TAKE_ALL;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_hold_cycles > 0)
            begin
                pix_bus.ready <= 1'b0;
                result_hold_cycles--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    TAKE_ALL:     pix_bus.ready <= 1'b1;
                    TAKE_HALF:    pix_bus.ready <= 1'($urandom_range(0, 1));
                    TAKE_QUARTER: pix_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:      pix_bus.ready <= ((mode_left % 7) < 3);
                endcase
            end
        end
    end

    function automatic void flag_mismatch(string field, logic [CH_W-1:0] want,
                                          logic [CH_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    endfunction

    always @(posedge clk)
    begin
        rgba_t want;
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: pixel result with no read request pending", $realtime);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_bus.pixel_red !== want.red)
                    flag_mismatch("pixel_red", want.red, pix_bus.pixel_red);
                if (pix_bus.pixel_green !== want.green)
                    flag_mismatch("pixel_green", want.green, pix_bus.pixel_green);
                if (pix_bus.pixel_blue !== want.blue)
                    flag_mismatch("pixel_blue", want.blue, pix_bus.pixel_blue);
                if (pix_bus.pixel_alpha !== want.alpha)
                    flag_mismatch("pixel_alpha", want.alpha, pix_bus.pixel_alpha);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rect_and_disc_raster_fill");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_shape_extremes();
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_RECT, -5, -5, 255, 255, 0, 255, 255, 255, 255));
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_RECT, 10, 10, 4, 4, 0, 255, 255, 255, 0));
        send_request(make_request(ACT_READ, 11, 11, 0, 0, 0, 0, 0, 0, 0));
        // empty shapes
        send_request(make_request(ACT_RECT, 0, 0, 0, 9, 0, 90, 80, 70, 60));
        send_request(make_request(ACT_RECT, 0, 0, 9, 0, 0, 90, 80, 70, 60));
        send_request(make_request(ACT_DISC, 0, 0, 0, 0, 0, 90, 80, 70, 60));
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_DISC, 64, 64, 0, 0, 5, 200, 100, 50, 128));
        send_request(make_request(ACT_READ, 64, 64, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 59, 64, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 68, 59, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_RECT, -2048, -2048, 255, 255, 0, 1, 2, 3, 4));
        send_request(make_request(ACT_RECT, 2047, 2047, 255, 255, 0, 1, 2, 3, 4));
        send_request(make_request(ACT_DISC, 64, 64, 0, 0, 255, 17, 34, 51, 200));
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0));
        // reads outside the canvas
        send_request(make_request(ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 128, 5, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 5, -2048, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 2047, 2047, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_NONE, 3, 3, 255, 255, 255, 255, 255, 255, 255));
        send_request(make_request(ACT_READ, 3, 3, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_canvas_registers();
        resize_canvas(0, 128);
        send_request(make_request(ACT_RECT, 0, 0, 10, 10, 0, 9, 9, 9, 255));
        send_request(make_request(ACT_READ, 0, 5, 0, 0, 0, 0, 0, 0, 0));
        resize_canvas(255, 0);
        send_request(make_request(ACT_DISC, 5, 5, 0, 0, 4, 9, 9, 9, 255));
        send_request(make_request(ACT_READ, 5, 5, 0, 0, 0, 0, 0, 0, 0));
        settle_block();
        set_register(REG_CANVAS_HEIGHT, 8'd255);
        send_request(make_request(ACT_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 200, 3, 0, 0, 0, 0, 0, 0, 0));
        resize_canvas(1, 1);
        send_request(make_request(ACT_RECT, -3, -3, 255, 255, 0, 40, 80, 160, 250));
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_DISC, 0, 0, 0, 0, 3, 70, 60, 50, 40));
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // indexes past the two registers are ignored
        settle_block();
        set_register(CFG_IDX_W'(2), 8'd5);
        set_register(CFG_IDX_W'(3), 8'd0);
        send_request(make_request(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        resize_canvas(37, 90);
        send_request(make_request(ACT_RECT, 30, 80, 20, 20, 0, 255, 0, 128, 191));
        send_request(make_request(ACT_READ, 36, 89, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 37, 89, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(ACT_READ, 30, 90, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_phases();
        int cols [7];
        int rows [7];
        cols = '{128, 64, 1, 128, 0, 255, 20};
        rows = '{128, 32, 128, 1, 0, 255, 100};
        cols[4] = $urandom_range(1, 255);
        rows[4] = $urandom_range(1, 255);
        for (int p = 0; p < 7; p++)
        begin
            resize_canvas(cols[p], rows[p]);
            repeat (RANDOM_PER_PHASE)
                send_request(random_request());
        end
    endtask

    task automatic test_result_stall();
        result_hold_cycles = 3000;
        repeat (20)
        begin
            send_request(make_request(ACT_READ, $urandom_range(0, 127), $urandom_range(0, 127),
                                      0, 0, 0, 0, 0, 0, 0));
            send_request(make_request(ACT_RECT, $urandom_range(0, 120), $urandom_range(0, 120),
                                      $urandom_range(1, 6), $urandom_range(1, 6), 0,
                                      $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        mismatch_count     = 0;
        result_hold_cycles = 0;
        quiet_cycles       = 0;
        burst_left         = $urandom_range(1, 16);
        clear_shadow();
        rst_n               <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.action      <= ACT_NONE;
        cmd_bus.x_pos       <= '0;
        cmd_bus.y_pos       <= '0;
        cmd_bus.rect_width  <= '0;
        cmd_bus.rect_height <= '0;
        cmd_bus.radius      <= '0;
        cmd_bus.red         <= '0;
        cmd_bus.green       <= '0;
        cmd_bus.blue        <= '0;
        cmd_bus.alpha       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_shape_extremes();
        test_canvas_registers();
        test_random_phases();
        test_result_stall();

        idle_sender();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("PASS rect_and_disc_raster_fill");
        else
            $display("FAIL rect_and_disc_raster_fill");
        $finish;
    end

endmodule
